[design/bpw_pkg.sv]
package bpw_pkg;

    // One input beat as it travels from the front end through the queue.
    typedef struct packed {
        logic signed [20:0] pos_x;
        logic signed [20:0] pos_y;
        logic signed [20:0] pos_z;
        logic signed [15:0] dir_l;
        logic signed [15:0] dir_m;
        logic signed [15:0] dir_n;
        logic        [27:0] freq_hz;
        logic               active;
    } t_item;

    // Speed of light in millimetres per second.
    localparam logic [127:0] LightMmPerS = 128'd299792458000;
    // Reciprocal of the speed of light, rounded half up, scaled by 2^101.
    localparam logic [127:0] RecipX2 = (128'd1 << 102) / LightMmPerS;
    localparam logic [127:0] RecipWide = (RecipX2 + 128'd1) >> 1;
    localparam logic [62:0] Recip = RecipWide[62:0];

    // CORDIC datapath widths (Q2.30 plus guard bits).
    localparam int XyW = 34;
    localparam int ZW = 34;
    localparam logic signed [XyW-1:0] CordicX0 = 34'sd652032874;
    localparam int AngleEntries = 24;

    // Arctangent table, unit 2^-32 turn.
    function automatic logic signed [ZW-1:0] angle_at(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[design/bpw_queue.sv]
module bpw_queue
    import bpw_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  t_item                    i_item,
    input  logic                     i_pop,
    output t_item                    o_item,
    output logic                     o_empty,
    output logic [$clog2(DEPTH):0]   o_level
);
    localparam int AW = $clog2(DEPTH);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_cnt;
    logic [AW-1:0]  n_wr;
    logic [AW-1:0]  n_rd;
    logic [AW:0]    n_cnt;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_level = r_cnt;
endmodule

[design/bpw_front.sv]
module bpw_front
    import bpw_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  t_item                    i_item,
    input  logic [$clog2(DEPTH):0]   i_level,
    output logic                     o_busy,
    output logic                     o_push,
    output t_item                    o_item
);
    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  w_accept;

    // Keep one queue slot free for the beat held in the front register.
    assign o_busy = (32'(i_level) >= DEPTH - 1);
    assign w_accept = i_start && !o_busy;

    // Inactive beamlets carry cleared operands so the math stays quiet.
    always_comb begin
        n_item = i_item;
        if (!i_item.active) begin
            n_item = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_push = r_valid;
    assign o_item = r_item;
endmodule

[design/bpw_phase.sv]
module bpw_phase
    import bpw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_item                 i_item,
    output logic                  o_valid,
    output logic                  o_active,
    output logic [1:0]            o_quad,
    output logic signed [ZW-1:0]  o_z
);
    localparam logic [31:0] RecipLo = Recip[31:0];
    localparam logic [30:0] RecipHi = Recip[62:32];

    logic [7:1] r_v;
    logic [7:1] r_act;

    // Stage 1: the three position by direction products.
    logic signed [36:0] r1_xm, r1_yl, r1_zn;
    logic        [27:0] r1_f;
    // Stage 2: path length.
    logic signed [37:0] r2_path;
    logic        [27:0] r2_f;
    // Stage 3: path times frequency in two halves.
    logic signed [47:0] r3_ph;
    logic signed [48:0] r3_pl;
    // Stage 4: full path times frequency.
    logic signed [65:0] r4_q;
    // Stage 5: partial products with the reciprocal.
    logic        [53:0] r5_ll, r5_ml;
    logic signed [54:0] r5_hl;
    logic        [52:0] r5_lh, r5_mh;
    logic signed [53:0] r5_hh;
    // Stage 6: two partial sums.
    logic [115:0] r6_a, r6_b;
    // Stage 7: quadrant and residual angle.
    logic [1:0]           r7_quad;
    logic signed [ZW-1:0] r7_z;

    logic [115:0] w_sum;
    logic [31:0]  w_phase;
    logic [31:0]  w_qsum;
    logic [1:0]   w_quad;
    logic [31:0]  w_res;

    assign w_sum = r6_a + r6_b;
    assign w_phase = w_sum[115:84];
    assign w_qsum = w_phase + 32'h2000_0000;
    assign w_quad = w_qsum[31:30];
    assign w_res = w_phase - {w_quad, 30'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[6:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= {r_act[6:1], i_item.active};

        r1_xm <= i_item.pos_x * i_item.dir_m;
        r1_yl <= i_item.pos_y * i_item.dir_l;
        r1_zn <= i_item.pos_z * i_item.dir_n;
        r1_f <= i_item.freq_hz;

        r2_path <= 38'(r1_xm) - 38'(r1_yl) + 38'(r1_zn);
        r2_f <= r1_f;

        r3_ph <= 48'($signed(r2_path[37:19]) * $signed({1'b0, r2_f}));
        r3_pl <= $signed({1'b0, r2_path[18:0]}) * $signed({1'b0, r2_f});

        r4_q <= (66'(r3_ph) <<< 19) + 66'(r3_pl);

        r5_ll <= r4_q[21:0] * RecipLo;
        r5_ml <= r4_q[43:22] * RecipLo;
        r5_hl <= 55'($signed(r4_q[65:44]) * $signed({1'b0, RecipLo}));
        r5_lh <= r4_q[21:0] * RecipHi;
        r5_mh <= r4_q[43:22] * RecipHi;
        r5_hh <= 54'($signed(r4_q[65:44]) * $signed({1'b0, RecipHi}));

        r6_a <= 116'(r5_ll) + (116'(r5_ml) << 22) + (116'(r5_lh) << 32);
        r6_b <= (116'(r5_mh) << 54) + (116'(unsigned'(116'(r5_hl))) << 44)
              + (116'(unsigned'(116'(r5_hh))) << 76);

        r7_quad <= w_quad;
        r7_z <= ZW'($signed(w_res));
    end

    assign o_valid = r_v[7];
    assign o_active = r_act[7];
    assign o_quad = r7_quad;
    assign o_z = r7_z;
endmodule

[design/bpw_cordic.sv]
module bpw_cordic
    import bpw_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_active,
    input  logic [1:0]            i_quad,
    input  logic signed [ZW-1:0]  i_z,
    output logic                  o_strobe,
    output logic signed [15:0]    o_re,
    output logic signed [15:0]    o_im
);
    logic                 w_v   [STAGES+1];
    logic                 w_act [STAGES+1];
    logic [1:0]           w_q   [STAGES+1];
    logic signed [XyW-1:0] w_x  [STAGES+1];
    logic signed [XyW-1:0] w_y  [STAGES+1];
    logic signed [ZW-1:0]  w_z  [STAGES+1];

    assign w_v[0] = i_valid;
    assign w_act[0] = i_active;
    assign w_q[0] = i_quad;
    assign w_x[0] = CordicX0;
    assign w_y[0] = '0;
    assign w_z[0] = i_z;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic                  r_v;
        logic                  r_act;
        logic [1:0]            r_q;
        logic signed [XyW-1:0] r_x, r_y;
        logic signed [ZW-1:0]  r_z;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= w_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_act <= w_act[i];
            r_q <= w_q[i];
            if (w_z[i] >= 0) begin
                r_x <= w_x[i] - (w_y[i] >>> i);
                r_y <= w_y[i] + (w_x[i] >>> i);
                r_z <= w_z[i] - angle_at(5'(i));
            end else begin
                r_x <= w_x[i] + (w_y[i] >>> i);
                r_y <= w_y[i] - (w_x[i] >>> i);
                r_z <= w_z[i] + angle_at(5'(i));
            end
        end

        assign w_v[i+1] = r_v;
        assign w_act[i+1] = r_act;
        assign w_q[i+1] = r_q;
        assign w_x[i+1] = r_x;
        assign w_y[i+1] = r_y;
        assign w_z[i+1] = r_z;
    end

    function automatic logic signed [15:0] to_q15(input logic signed [XyW-1:0] v);
        logic signed [XyW:0]    t;
        logic signed [XyW-15:0] r;
        logic signed [15:0]     s;
        t = (XyW+1)'(v) + (XyW+1)'(16384);
        r = (XyW-14)'(t >>> 15);
        if (r > (XyW-14)'(32767)) begin
            s = 16'sh7FFF;
        end else if (r < -(XyW-14)'(32768)) begin
            s = -16'sh8000;
        end else begin
            s = r[15:0];
        end
        return s;
    endfunction

    logic signed [XyW-1:0] w_rx, w_ry;
    logic                  r_strobe;
    logic signed [15:0]    r_re, r_im;

    always_comb begin
        unique case (w_q[STAGES])
            2'd0: begin
                w_rx = w_x[STAGES];
                w_ry = w_y[STAGES];
            end
            2'd1: begin
                w_rx = -w_y[STAGES];
                w_ry = w_x[STAGES];
            end
            2'd2: begin
                w_rx = -w_x[STAGES];
                w_ry = -w_y[STAGES];
            end
            default: begin
                w_rx = w_y[STAGES];
                w_ry = -w_x[STAGES];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_v[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_re <= w_act[STAGES] ? to_q15(w_rx) : '0;
        r_im <= w_act[STAGES] ? to_q15(w_ry) : '0;
    end

    assign o_strobe = r_strobe;
    assign o_re = r_re;
    assign o_im = r_im;
endmodule

[design/beamformer_phase_weight.sv]
// Steering weight of one antenna element for a delay-and-sum beamformer.
//
// Input channel: a beat is taken at a rising clock edge where start is high
// and busy is low. It carries the element position, the direction cosines,
// the subband frequency and the beamlet active flag, one port per field.
// Output channel: each result is shown on o_weight_re and o_weight_im for
// exactly one cycle, marked by o_strobe. The receiver cannot stall, so the
// back end never stops and results leave in the order the beats came in.
// Throughput is one beat per cycle, sustained.
// From the accepting edge to the strobe, a beat passes one front register,
// one queue slot, seven stages of path and phase arithmetic (the long phase
// product is split into 22-bit by 32-bit and 22-bit by 31-bit partial
// products), one CORDIC stage per iteration and one output rounding stage.
// Busy rises only when the queue between front and back nears full, which
// does not happen while the back end drains one beat per cycle.
// Synchronous reset empties the queue and clears every valid flag; no
// result is shown after reset until a new beat is accepted.
module beamformer_phase_weight
    import bpw_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [20:0] i_pos_x,
    input  logic signed [20:0] i_pos_y,
    input  logic signed [20:0] i_pos_z,
    input  logic signed [15:0] i_dir_l,
    input  logic signed [15:0] i_dir_m,
    input  logic signed [15:0] i_dir_n,
    input  logic        [27:0] i_freq_hz,
    input  logic               i_beamlet_active,
    output logic               o_strobe,
    output logic signed [15:0] o_weight_re,
    output logic signed [15:0] o_weight_im
);
    t_item                       w_in_item;
    t_item                       w_push_item;
    t_item                       w_pop_item;
    logic                        w_push;
    logic                        w_empty;
    logic [$clog2(QUEUE_DEPTH):0] w_level;

    logic                  w_ph_valid;
    logic                  w_ph_active;
    logic [1:0]            w_ph_quad;
    logic signed [ZW-1:0]  w_ph_z;

    always_comb begin
        w_in_item.pos_x = i_pos_x;
        w_in_item.pos_y = i_pos_y;
        w_in_item.pos_z = i_pos_z;
        w_in_item.dir_l = i_dir_l;
        w_in_item.dir_m = i_dir_m;
        w_in_item.dir_n = i_dir_n;
        w_in_item.freq_hz = i_freq_hz;
        w_in_item.active = i_beamlet_active;
    end

    bpw_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (w_in_item),
        .i_level (w_level),
        .o_busy  (busy),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    // The back end takes a beat out of the queue whenever one is waiting.
    bpw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (!w_empty),
        .o_item  (w_pop_item),
        .o_empty (w_empty),
        .o_level (w_level)
    );

    bpw_phase u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_empty),
        .i_item   (w_pop_item),
        .o_valid  (w_ph_valid),
        .o_active (w_ph_active),
        .o_quad   (w_ph_quad),
        .o_z      (w_ph_z)
    );

    bpw_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_ph_valid),
        .i_active (w_ph_active),
        .i_quad   (w_ph_quad),
        .i_z      (w_ph_z),
        .o_strobe (o_strobe),
        .o_re     (o_weight_re),
        .o_im     (o_weight_im)
    );
endmodule
